[hdl/smms_pkg.sv]
// ----------------------------------------------------------------------------
// smms_pkg
// Shared types and fixed field widths for the streaming run statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package smms_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MINMAX_W = 16;
	localparam int MEAN_W   = 24;
	localparam int STD_W    = 24;
	localparam int TOTAL_W  = 13;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} data_t;

	typedef struct packed {
		logic signed [MINMAX_W-1:0] min_value;
		logic signed [MINMAX_W-1:0] max_value;
		logic signed [MEAN_W-1:0]   mean_q8;
		logic [STD_W-1:0]           std_q8;
		logic [TOTAL_W-1:0]         sample_total;
		logic                       overflow_flag;
	} result_t;

	typedef enum logic [2:0] {
		OP_IDLE     = 3'd0,
		OP_MUL_NSQ  = 3'd1,
		OP_MUL_SS   = 3'd2,
		OP_MUL_NN   = 3'd3,
		OP_DIV_MEAN = 3'd4,
		OP_DIV_VAR  = 3'd5,
		OP_SQRT     = 3'd6
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic step;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

`default_nettype wire

[hdl/stream_min_max_mean_std.sv]
// Takes one data word per cycle while a run accumulates.
// After the word marked last come a flush state, the multiply, divide and root
// steps and an output state that loads the result; data stalls until it is loaded.
// The result register holds one word, so the next run accumulates while it waits.
// Asynchronous active-low reset clears the run and drops any held result.
// ----------------------------------------------------------------------------
// stream_min_max_mean_std
// Running minimum, maximum, mean and population standard deviation per run.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_min_max_mean_std #(
	parameter int SAMPLE_BITS   = 16,
	parameter int MAX_SAMPLES   = 4096,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          data_valid,
	output logic               data_stall,
	input  smms_pkg::data_t    data,
	output logic               result_valid,
	input  wire logic          result_stall,
	output smms_pkg::result_t  result
);
	import smms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	smms_ctrl #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_SAMPLES  (MAX_SAMPLES),
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.last_sample(data.last_sample),
		.data_stall (data_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	smms_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_SAMPLES  (MAX_SAMPLES),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data        (data),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

`default_nettype wire

[hdl/smms_ctrl.sv]
// ----------------------------------------------------------------------------
// smms_ctrl
// Sequencer: accumulation, then the end-of-run multiply, divide and root steps.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_ctrl #(
	parameter int SAMPLE_BITS   = 16,
	parameter int MAX_SAMPLES   = 4096,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          data_valid,
	input  wire logic          last_sample,
	output logic               data_stall,
	input  smms_pkg::sts_t     sts,
	output smms_pkg::cmd_t     cmd
);
	import smms_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int MW   = SUMW + FRACTION_BITS;
	localparam int NUMW = 2 * SUMW;
	localparam int DIVW = NUMW + 2 * FRACTION_BITS;
	localparam int RW   = (DIVW + 1) / 2;
	localparam int CNTW = $clog2(DIVW + 1);

	typedef enum logic [8:0] {
		S_ACC      = 9'b000000001,
		S_FLUSH    = 9'b000000010,
		S_MUL_NSQ  = 9'b000000100,
		S_MUL_SS   = 9'b000001000,
		S_MUL_NN   = 9'b000010000,
		S_DIV_MEAN = 9'b000100000,
		S_DIV_VAR  = 9'b001000000,
		S_SQRT     = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	state_t          state_q, state_d, nxt;
	logic [CNTW-1:0] cnt_q, cnt_d, limit;
	logic            iter, accept;

	assign accept     = data_valid && (state_q == S_ACC);
	assign data_stall = (state_q != S_ACC);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		nxt          = S_ACC;
		limit        = '0;
		iter         = 1'b0;
		cmd.op       = OP_IDLE;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.acc      = accept;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_ACC: begin
				if (accept && last_sample) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_MUL_NSQ;
			end
			S_MUL_NSQ: begin
				cmd.op = OP_MUL_NSQ;
				limit  = CNTW'(CW);
				nxt    = S_MUL_SS;
				iter   = 1'b1;
			end
			S_MUL_SS: begin
				cmd.op = OP_MUL_SS;
				limit  = CNTW'(SUMW);
				nxt    = S_MUL_NN;
				iter   = 1'b1;
			end
			S_MUL_NN: begin
				cmd.op = OP_MUL_NN;
				limit  = CNTW'(CW);
				nxt    = S_DIV_MEAN;
				iter   = 1'b1;
			end
			S_DIV_MEAN: begin
				cmd.op = OP_DIV_MEAN;
				limit  = CNTW'(MW);
				nxt    = S_DIV_VAR;
				iter   = 1'b1;
			end
			S_DIV_VAR: begin
				cmd.op = OP_DIV_VAR;
				limit  = CNTW'(DIVW);
				nxt    = S_SQRT;
				iter   = 1'b1;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				limit  = CNTW'(RW);
				nxt    = S_OUT;
				iter   = 1'b1;
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
		// count 0 loads operands, counts 1..limit step the unit
		if (iter) begin
			cmd.load = (cnt_q == '0);
			cmd.step = (cnt_q != '0);
			if (cnt_q == limit) begin
				cnt_d   = '0;
				state_d = nxt;
			end else begin
				cnt_d = cnt_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(data_valid && !data_stall && last_sample) |=> (state_q == S_FLUSH))
		else $error("last word did not start the end-of-run sequence");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("result overwritten while held");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNTW'(DIVW)) && ((cnt_q == '0) || iter))
		else $error("step counter out of range");

endmodule

`default_nettype wire

[hdl/smms_dp.sv]
// ----------------------------------------------------------------------------
// smms_dp
// Datapath: run accumulators, shift-add multiplier, restoring divider,
// bit-pair square root and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_dp #(
	parameter int SAMPLE_BITS   = 16,
	parameter int MAX_SAMPLES   = 4096,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  smms_pkg::data_t    data,
	input  smms_pkg::cmd_t     cmd,
	output smms_pkg::sts_t     sts,
	output smms_pkg::result_t  result,
	output logic               result_valid,
	input  wire logic          result_stall
);
	import smms_pkg::*;

	localparam int SW   = SAMPLE_BITS;
	localparam int EXTW = (SW > SAMPLE_W) ? SW : SAMPLE_W;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SW + CW;
	localparam int SQW  = 2 * SW + CW;
	localparam int NUMW = 2 * SUMW;
	localparam int DENW = 2 * CW;
	localparam int DIVW = NUMW + 2 * FRACTION_BITS;
	localparam int RW   = (DIVW + 1) / 2;
	localparam int VW   = 2 * RW;
	localparam logic [CW-1:0] MAXC = CW'(MAX_SAMPLES);

	// run accumulators
	logic signed [SW-1:0]   min_q, max_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]         sumsq_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [2*SW-1:0]        sq_s1;
	logic                   sq_vld_s1;

	logic [EXTW-1:0]        raw_ext;
	logic signed [SW-1:0]   s;
	logic signed [2*SW-1:0] sq_full;
	logic                   full, take;
	logic [SUMW-1:0]        sum_abs;

	// end-of-run units
	logic [NUMW-1:0]        ma_q, mp_q, num_q;
	logic [SUMW-1:0]        mb_q;
	logic [DENW-1:0]        den_q, dvs_q, rem_q;
	logic [DIVW-1:0]        quo_q;
	logic [MEAN_W-1:0]      mean_q, mean_mag;
	logic [VW-1:0]          rad_q;
	logic [RW+1:0]          srem_q;
	logic [RW-1:0]          root_q;

	logic [DENW:0]          div_sh, div_diff;
	logic                   div_ge;
	logic [RW+3:0]          sq_t, sq_trial, sq_diff;
	logic                   sq_ge;
	logic                   is_mul, is_div;

	result_t                result_q;
	logic                   result_valid_q;

	assign raw_ext  = EXTW'($unsigned(data.sample));
	assign s        = $signed(raw_ext[SW-1:0]);
	assign sq_full  = s * s;
	assign full     = (count_q == MAXC);
	assign take     = cmd.acc && !full;
	assign sum_abs  = sum_q[SUMW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

	assign is_mul   = (cmd.op == OP_MUL_NSQ) || (cmd.op == OP_MUL_SS) ||
	                  (cmd.op == OP_MUL_NN);
	assign is_div   = (cmd.op == OP_DIV_MEAN) || (cmd.op == OP_DIV_VAR);

	assign div_sh   = {rem_q, quo_q[DIVW-1]};
	assign div_ge   = (div_sh >= {1'b0, dvs_q});
	assign div_diff = div_sh - {1'b0, dvs_q};

	assign sq_t     = {srem_q, rad_q[VW-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_t >= sq_trial);
	assign sq_diff  = sq_t - sq_trial;

	assign mean_mag = MEAN_W'(quo_q);

	// accumulators and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			sum_q     <= '0;
			sumsq_q   <= '0;
			sq_vld_s1 <= 1'b0;
		end else begin
			sq_vld_s1 <= take;
			if (cmd.out_load) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end else begin
				if (cmd.acc) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
						sum_q   <= sum_q + SUMW'(s);
					end
				end
				if (sq_vld_s1) begin
					sumsq_q <= sumsq_q + SQW'(sq_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= $unsigned(sq_full);
		if (take) begin
			if (count_q == '0) begin
				min_q <= s;
				max_q <= s;
			end else begin
				if (s < min_q) begin
					min_q <= s;
				end
				if (s > max_q) begin
					max_q <= s;
				end
			end
		end
	end

	// multiply, divide and root; each result is picked up by the next load
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.op)
				OP_MUL_NSQ: begin
					ma_q <= NUMW'(sumsq_q);
					mb_q <= SUMW'(count_q);
					mp_q <= '0;
				end
				OP_MUL_SS: begin
					num_q <= mp_q;
					ma_q  <= NUMW'(sum_abs);
					mb_q  <= sum_abs;
					mp_q  <= '0;
				end
				OP_MUL_NN: begin
					num_q <= num_q - mp_q;
					ma_q  <= NUMW'(count_q);
					mb_q  <= SUMW'(count_q);
					mp_q  <= '0;
				end
				OP_DIV_MEAN: begin
					den_q <= DENW'(mp_q);
					dvs_q <= DENW'(count_q);
					rem_q <= '0;
					quo_q <= DIVW'(sum_abs) << (DIVW - SUMW);
				end
				OP_DIV_VAR: begin
					mean_q <= sum_q[SUMW-1] ? (-mean_mag) : mean_mag;
					dvs_q  <= den_q;
					rem_q  <= '0;
					quo_q  <= DIVW'(num_q) << (2 * FRACTION_BITS);
				end
				OP_SQRT: begin
					rad_q  <= VW'(quo_q);
					srem_q <= '0;
					root_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			if (is_mul) begin
				if (mb_q[0]) begin
					mp_q <= mp_q + ma_q;
				end
				ma_q <= {ma_q[NUMW-2:0], 1'b0};
				mb_q <= {1'b0, mb_q[SUMW-1:1]};
			end
			if (is_div) begin
				rem_q <= div_ge ? div_diff[DENW-1:0] : div_sh[DENW-1:0];
				quo_q <= {quo_q[DIVW-2:0], div_ge};
			end
			if (cmd.op == OP_SQRT) begin
				srem_q <= sq_ge ? sq_diff[RW+1:0] : sq_t[RW+1:0];
				root_q <= {root_q[RW-2:0], sq_ge};
				rad_q  <= {rad_q[VW-3:0], 2'b00};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.min_value     <= MINMAX_W'(min_q);
			result_q.max_value     <= MINMAX_W'(max_q);
			result_q.mean_q8       <= $signed(mean_q);
			result_q.std_q8        <= STD_W'(root_q);
			result_q.sample_total  <= TOTAL_W'(count_q);
			result_q.overflow_flag <= ovf_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign sts.out_full = result_valid_q && result_stall;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC)
		else $error("sample count beyond limit");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flagged before the run was full");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && is_div) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[dv/stream_min_max_mean_std_test.sv]
// ----------------------------------------------------------------------------
// stream_min_max_mean_std_test
// Checks the run statistics block against a predictor kept in the bench. A
// short table covers extremes, truncation of the mean, a full-length run and a
// run with dropped words. Random runs follow. Both sides idle and stall at
// random, with one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module stream_min_max_mean_std_test;
	timeunit 1ns;
	timeprecision 1ps;

	import smms_pkg::*;

	localparam int  MAX_RUN    = 4096;
	localparam int  FRAC       = 8;
	localparam int  RAND_WORDS = 700;
	localparam int  HOLD_OFF   = 700;
	localparam int  SETTLE     = 300;
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct {
		data_t   word;
		int      reps;
		bit      known;
		result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    data_valid;
	logic    data_stall;
	data_t   data;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// predictor state
	longint          acc_min, acc_max, acc_sum;
	longint unsigned acc_sumsq, acc_count;
	bit              acc_dropped;

	result_t pending_stats[$];
	int      fails;
	int      results_seen;
	int      overflow_runs;
	int      words_sent;
	longint  cycles;
	bit      calm;
	bit      long_hold_done;

	stream_min_max_mean_std u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data         (data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_run();
		acc_min     = 0;
		acc_max     = 0;
		acc_sum     = 0;
		acc_sumsq   = 0;
		acc_count   = 0;
		acc_dropped = 1'b0;
	endfunction

	// Folds one word into the run; returns 1 with the run statistics on last word.
	function automatic bit fold_sample(input data_t w, output result_t r);
		longint          s, mean_full;
		longint unsigned n, spread, var_q16, root, cand;
		logic [127:0]    scaled;
		r = '0;
		s = longint'(w.sample);
		if (acc_count < MAX_RUN) begin
			if (acc_count == 0) begin
				acc_min = s;
				acc_max = s;
			end else begin
				if (s < acc_min)
					acc_min = s;
				if (s > acc_max)
					acc_max = s;
			end
			acc_sum   += s;
			acc_sumsq += longint'(s * s);
			acc_count++;
		end else begin
			acc_dropped = 1'b1;
		end
		if (!w.last_sample)
			return 1'b0;
		n         = acc_count;
		mean_full = (acc_sum * (longint'(1) << FRAC)) / longint'(n);
		spread    = n * acc_sumsq - longint'(acc_sum * acc_sum);
		scaled    = {64'd0, spread} << (2 * FRAC);
		var_q16   = 64'(scaled / {64'd0, n * n});
		root      = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= var_q16)
				root = cand;
		end
		r.min_value     = acc_min[15:0];
		r.max_value     = acc_max[15:0];
		r.mean_q8       = mean_full[23:0];
		r.std_q8        = root[23:0];
		r.sample_total  = n[12:0];
		r.overflow_flag = acc_dropped;
		clear_run();
		return 1'b1;
	endfunction

	function automatic result_t outcome(input int mn, input int mx, input int mean,
			input int sd, input int tot, input bit ovf);
		result_t r;
		r.min_value     = mn[15:0];
		r.max_value     = mx[15:0];
		r.mean_q8       = mean[23:0];
		r.std_q8        = sd[23:0];
		r.sample_total  = tot[12:0];
		r.overflow_flag = ovf;
		return r;
	endfunction

	function automatic stim_row_t row(input int s, input bit l, input int reps);
		stim_row_t t;
		t.word.sample      = s[15:0];
		t.word.last_sample = l;
		t.reps             = reps;
		t.known            = 1'b0;
		t.want             = '0;
		return t;
	endfunction

	function automatic stim_row_t row_known(input int s, input bit l, input int reps,
			input result_t want);
		stim_row_t t;
		t       = row(s, l, reps);
		t.known = 1'b1;
		t.want  = want;
		return t;
	endfunction

	task automatic offer_word(input data_t w, input bit known, input result_t want);
		result_t r;
		while (!calm && $urandom_range(99) < 19) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data       <= w;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		words_sent++;
		if (fold_sample(w, r))
			pending_stats.push_back(known ? want : r);
		@(negedge clk);
	endtask

	task automatic report_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_stats.size() == 0) begin
				$display("%0t unexpected result word: expected none, got %h", $time, result);
				fails++;
			end else begin
				exp_r = pending_stats.pop_front();
				if (result.overflow_flag)
					overflow_runs++;
				report_field("min_value", exp_r.min_value, result.min_value);
				report_field("max_value", exp_r.max_value, result.max_value);
				report_field("mean_q8", exp_r.mean_q8, result.mean_q8);
				report_field("std_q8", {40'd0, exp_r.std_q8}, {40'd0, result.std_q8});
				report_field("sample_total", {51'd0, exp_r.sample_total},
					{51'd0, result.sample_total});
				report_field("overflow_flag", {63'd0, exp_r.overflow_flag},
					{63'd0, result.overflow_flag});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results still expected", $time, pending_stats.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stall, one long hold-off so the block backs up
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= 25) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF) @(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 19);
			end
		end
	end

	initial begin
		stim_row_t stim_rows[19];
		data_t     w;
		int        rnd_words, run_len;
		bit        paused;
		arst_n         = 1'b0;
		data_valid     = 1'b0;
		data           = '0;
		calm           = 1'b0;
		long_hold_done = 1'b0;
		fails          = 0;
		results_seen   = 0;
		overflow_runs  = 0;
		words_sent     = 0;
		cycles         = 0;
		rnd_words      = 0;
		paused         = 1'b0;
		clear_run();

		stim_rows = '{
			row_known(0, 1, 1, outcome(0, 0, 0, 0, 1, 0)),
			row_known(32767, 1, 1, outcome(32767, 32767, 8388352, 0, 1, 0)),
			row_known(-32768, 1, 1, outcome(-32768, -32768, -8388608, 0, 1, 0)),
			row(32767, 0, 1),
			row(-32768, 1, 1),
			row(5, 0, 1),
			row_known(5, 1, 1, outcome(5, 5, 1280, 0, 2, 0)),
			// mean -1/3 (-85.33 in Q8): must truncate toward zero
			row(-1, 0, 1),
			row(0, 0, 1),
			row(0, 1, 1),
			// widest spread
			row(-32768, 0, 1),
			row(32767, 0, 1),
			row(-32768, 0, 1),
			row(32767, 1, 1),
			// run of exactly the limit
			row(-32768, 0, MAX_RUN - 1),
			row_known(-32768, 1, 1, outcome(-32768, -32768, -8388608, 0, MAX_RUN, 0)),
			// over the limit: dropped words leave min/max/sum alone, dropped last ends run
			row(32767, 0, MAX_RUN),
			row(-32768, 0, 2),
			row_known(1, 1, 1, outcome(32767, 32767, 8388352, 0, MAX_RUN, 1))
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			repeat (stim_rows[i].reps)
				offer_word(stim_rows[i].word, stim_rows[i].known, stim_rows[i].want);

		while (rnd_words < RAND_WORDS) begin
			run_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if (!paused && rnd_words >= 300) begin
				data_valid <= 1'b0;
				wait (pending_stats.size() == 0);
				@(negedge clk);
				paused = 1'b1;
			end
			for (int k = 0; k < run_len; k++) begin
				calm = (rnd_words >= 420 && rnd_words < 560);
				case ($urandom_range(9))
					7:       w.sample = 16'sd32767;
					8:       w.sample = -16'sd32768;
					5, 6:    w.sample = 16'($signed($urandom_range(64)) - 32);
					9:       w.sample = 16'($urandom_range(3));
					default: w.sample = 16'($urandom);
				endcase
				w.last_sample = (k == run_len - 1);
				offer_word(w, 1'b0, '0);
				rnd_words++;
			end
		end
		calm       = 1'b0;
		data_valid <= 1'b0;

		wait (pending_stats.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("%0d words sent in %0d runs, %0d runs with dropped words", words_sent,
			results_seen, overflow_runs);
		$display("%0d mismatches, long result hold-off and drain pause done", fails);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[stream_min_max_mean_std.f]
hdl/smms_pkg.sv
hdl/smms_ctrl.sv
hdl/smms_dp.sv
hdl/stream_min_max_mean_std.sv
dv/stream_min_max_mean_std_test.sv
